### rtl/core/counting_semaphore_fifo_wait_queue_assert.svh
// Assertion macros for the semaphore block.
`ifndef COUNTING_SEMAPHORE_FIFO_WAIT_QUEUE_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAIT_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CSFWQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSFWQ_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSFWQ_ASSERT(label, clk, rst_n, prop, msg)
`define CSFWQ_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

### rtl/core/csfwq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csfwq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COUNT_W         = 16;
    localparam int INIT_W          = 15;
    localparam int TID_W           = 8;
    localparam int ST_W            = 2;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_CLOSED = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic [1:0] {
        OP_WAIT   = 2'd0,
        OP_SIGNAL = 2'd1,
        OP_OPEN   = 2'd2,
        OP_CLOSE  = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [TID_W-1:0] thread_id;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic             caller_blocked;
        logic             released_valid;
        logic [TID_W-1:0] released_thread;
        logic             last;
    } t_res;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic drain;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic close_drain;
        logic last_pop;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/core/counting_semaphore_fifo_wait_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Counting semaphore with a FIFO of waiting thread ids. A command is taken when
// start is high and busy is low; its results come out on o_res, each valid for
// exactly one cycle while o_res_strobe is high, and cannot be held off, so the
// receiver must take every strobed result. Wait, signal and open give one
// result, registered behind the command capture and the execute state of the
// controller, and the next command may be taken in the same cycle that result
// is strobed; busy holds new commands off until then. Close with N waiters
// gives N results on consecutive cycles, one per queue read, with busy high
// until the last queue read; with no waiters it behaves as the others.
// initial_count is written through the cfg channel, always ready.

module counting_semaphore_fifo_wait_queue
    import csfwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_cmd              i_cmd,
    output logic                   o_res_strobe,
    output t_res                   o_res,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [INIT_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    csfwq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    csfwq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_in   (i_cmd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_res      (o_res),
        .o_res_vld  (o_res_strobe)
    );

endmodule

`default_nettype wire

### rtl/core/csfwq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module csfwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/csfwq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "counting_semaphore_fifo_wait_queue_assert.svh"

module csfwq_dp
    import csfwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd_in,
    input  wire logic              i_cfg_we,
    input  wire logic [INIT_W-1:0] i_cfg_data,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    output t_res                   o_res,
    output logic                   o_res_vld
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_op                        r_op;
    logic [TID_W-1:0]           r_tid;
    logic [INIT_W-1:0]          r_init;
    logic signed [COUNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]           r_head, n_head;
    logic [PTR_W-1:0]           r_tail, n_tail;
    logic [FILL_W-1:0]          r_fill, n_fill;
    logic                       r_closed, n_closed;
    t_res                       r_res, n_res;
    logic                       r_res_vld, n_res_vld;

    logic                       we;
    logic [TID_W-1:0]           rd_data;
    logic [PTR_W-1:0]           head_nxt;
    logic [PTR_W-1:0]           tail_nxt;
    logic                       blk;
    logic                       full;
    logic                       sig_ok;
    logic                       pop_ok;
    logic [ST_W-1:0]            ok_st;

    csfwq_ram #(
        .WIDTH (TID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (r_tid),
        .i_raddr (n_head),
        .o_rdata (rd_data)
    );

    assign head_nxt = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
    assign tail_nxt = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
    assign blk      = (r_count <= 16'sd0);
    assign full     = (r_fill == FILL_W'(QUEUE_DEPTH)) || (r_count == COUNT_MIN);
    assign sig_ok   = (r_count != COUNT_MAX);
    assign pop_ok   = r_count[COUNT_W-1] && (r_fill != '0);
    assign ok_st    = r_closed ? ST_CLOSED : ST_OK;

    assign o_sts.close_drain = (r_op == OP_CLOSE) && (r_fill != '0);
    assign o_sts.last_pop    = (r_fill == FILL_W'(1));

    always_comb begin
        n_count   = r_count;
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_closed  = r_closed;
        n_res     = r_res;
        n_res_vld = 1'b0;
        we        = 1'b0;
        if (i_cmd.exec) begin
            n_res_vld  = 1'b1;
            n_res      = '0;
            n_res.last = 1'b1;
            n_res.status = ok_st;
            case (r_op)
                OP_WAIT: begin
                    if (!blk) begin
                        n_count = r_count - 16'sd1;
                    end else if (full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        we                   = 1'b1;
                        n_count              = r_count - 16'sd1;
                        n_tail               = tail_nxt;
                        n_fill               = r_fill + FILL_W'(1);
                        n_res.caller_blocked = 1'b1;
                    end
                end
                OP_SIGNAL: begin
                    if (sig_ok) begin
                        n_count = r_count + 16'sd1;
                        if (pop_ok) begin
                            n_head                = head_nxt;
                            n_fill                = r_fill - FILL_W'(1);
                            n_res.released_valid  = 1'b1;
                            n_res.released_thread = rd_data;
                        end
                    end
                end
                OP_OPEN: begin
                    n_count      = {1'b0, r_init};
                    n_head       = '0;
                    n_tail       = '0;
                    n_fill       = '0;
                    n_closed     = 1'b0;
                    n_res.status = ST_OK;
                end
                OP_CLOSE: begin
                    n_count      = '0;
                    n_closed     = 1'b1;
                    n_res.status = ST_CLOSED;
                    if (r_fill == '0) begin
                        n_head = '0;
                        n_tail = '0;
                    end else begin
                        n_res_vld = 1'b0;
                    end
                end
                default: begin
                    n_res_vld = 1'b0;
                end
            endcase
        end else if (i_cmd.drain) begin
            n_res_vld             = 1'b1;
            n_res.status          = ST_CLOSED;
            n_res.caller_blocked  = 1'b0;
            n_res.released_valid  = 1'b1;
            n_res.released_thread = rd_data;
            n_res.last            = o_sts.last_pop;
            n_fill                = r_fill - FILL_W'(1);
            if (o_sts.last_pop) begin
                n_head = '0;
                n_tail = '0;
            end else begin
                n_head = head_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_count   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_closed  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_init <= i_cfg_data;
            end
            r_count   <= n_count;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fill    <= n_fill;
            r_closed  <= n_closed;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_cmd_in.op;
            r_tid <= i_cmd_in.thread_id;
        end
        r_res <= n_res;
    end

    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

    `CSFWQ_ASSERT(a_fill_range, i_clk, i_rst_n, r_fill <= FILL_W'(QUEUE_DEPTH), "fill above depth")
    `CSFWQ_ASSERT(a_drain_nonempty, i_clk, i_rst_n, i_cmd.drain |-> (r_fill != '0), "drain on empty queue")
    `CSFWQ_ASSERT(a_drain_end, i_clk, i_rst_n, (i_cmd.drain && o_sts.last_pop) |=> ((r_fill == '0) && (r_head == '0) && (r_tail == '0)), "queue not reset after drain")

endmodule

`default_nettype wire

### rtl/core/csfwq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module csfwq_ctrl
    import csfwq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_sts.close_drain ? S_DRAIN : S_IDLE;
            end
            S_DRAIN: begin
                if (i_sts.last_pop) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_cmd.drain  = (r_state == S_DRAIN);

endmodule

`default_nettype wire
